### hw/rtl/time_of_day_shift_and_difference_assert.svh
// Assertion macros for the time-of-day shift and difference block.
// Uses no package; included by files that carry concurrent checks.
`ifndef TIME_OF_DAY_SHIFT_AND_DIFFERENCE_ASSERT_SVH
`define TIME_OF_DAY_SHIFT_AND_DIFFERENCE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TOD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tod: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define TOD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tod: next-cycle check failed");

`endif

### hw/rtl/tod_pkg.sv
// Shared types and constants for the time-of-day shift and difference block.
// Depends on nothing; used by tod_calc and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

    // Operation codes
    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_FWD  = 2'd1,
        OP_BACK = 2'd2,
        OP_DIFF = 2'd3
    } t_tod_op;

    // Field limits and moduli
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd59;
    localparam logic [5:0] HOUR_MOD   = 6'd24;
    localparam logic [6:0] MINSEC_MOD = 7'd60;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod_time;

    typedef struct packed {
        t_tod_op    op;
        logic [4:0] in_hour;
        logic [5:0] in_minute;
        logic [5:0] in_second;
    } t_tod_req;

    typedef struct packed {
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [5:0] now_second;
        logic [4:0] diff_hour;
        logic [5:0] diff_minute;
        logic [5:0] diff_second;
        logic       rejected;
    } t_tod_rsp;

endpackage

`default_nettype wire

### hw/rtl/tod_calc.sv
// Combinational time-of-day arithmetic: set, shift with wrap, difference.
// Depends on tod_pkg; works in h:m:s with carries instead of a seconds count.
`timescale 1ns / 1ps
`default_nettype none

module tod_calc (
    input  wire tod_pkg::t_tod_req  i_req,
    input  wire tod_pkg::t_tod_time i_time,
    output tod_pkg::t_tod_rsp       o_rsp
);

    // Add two in-range times, wrap at 24 hours
    function automatic tod_pkg::t_tod_time f_add(tod_pkg::t_tod_time a,
                                                 tod_pkg::t_tod_time b);
        logic [6:0] s_sum;
        logic [6:0] m_sum;
        logic [5:0] h_sum;
        logic       cs;
        logic       cm;
        tod_pkg::t_tod_time r;
        s_sum    = {1'b0, a.second} + {1'b0, b.second};
        cs       = (s_sum >= tod_pkg::MINSEC_MOD);
        r.second = cs ? 6'(s_sum - tod_pkg::MINSEC_MOD) : s_sum[5:0];
        m_sum    = {1'b0, a.minute} + {1'b0, b.minute} + {6'd0, cs};
        cm       = (m_sum >= tod_pkg::MINSEC_MOD);
        r.minute = cm ? 6'(m_sum - tod_pkg::MINSEC_MOD) : m_sum[5:0];
        h_sum    = {1'b0, a.hour} + {1'b0, b.hour} + {5'd0, cm};
        r.hour   = (h_sum >= tod_pkg::HOUR_MOD) ? 5'(h_sum - tod_pkg::HOUR_MOD)
                                                 : h_sum[4:0];
        return r;
    endfunction

    // Subtract two in-range times, wrap below midnight
    function automatic tod_pkg::t_tod_time f_sub(tod_pkg::t_tod_time a,
                                                 tod_pkg::t_tod_time b);
        logic [6:0] s_d;
        logic [6:0] m_d;
        logic [5:0] h_d;
        logic       bs;
        logic       bm;
        tod_pkg::t_tod_time r;
        s_d      = {1'b0, a.second} - {1'b0, b.second};
        bs       = s_d[6];
        r.second = bs ? 6'(s_d + tod_pkg::MINSEC_MOD) : s_d[5:0];
        m_d      = {1'b0, a.minute} - {1'b0, b.minute} - {6'd0, bs};
        bm       = m_d[6];
        r.minute = bm ? 6'(m_d + tod_pkg::MINSEC_MOD) : m_d[5:0];
        h_d      = {1'b0, a.hour} - {1'b0, b.hour} - {5'd0, bm};
        r.hour   = h_d[5] ? 5'(h_d + tod_pkg::HOUR_MOD) : h_d[4:0];
        return r;
    endfunction

    tod_pkg::t_tod_time w_opnd;
    tod_pkg::t_tod_time w_next;
    tod_pkg::t_tod_time w_diff;
    logic               w_bad;
    logic               w_t_ge_o;

    assign w_opnd = '{hour: i_req.in_hour, minute: i_req.in_minute,
                      second: i_req.in_second};

    // Range check on the operand, for every operation
    assign w_bad = (i_req.in_hour > tod_pkg::HOUR_MAX)
                || (i_req.in_minute > tod_pkg::MINSEC_MAX)
                || (i_req.in_second > tod_pkg::MINSEC_MAX);

    // Fields are in range, so the packed word orders like the seconds count
    assign w_t_ge_o = (i_time >= w_opnd);

    // Select the new stored time and the difference
    always_comb begin
        w_next = i_time;
        w_diff = '0;
        if (!w_bad) begin
            case (i_req.op)
                tod_pkg::OP_SET:  w_next = w_opnd;
                tod_pkg::OP_FWD:  w_next = f_add(i_time, w_opnd);
                tod_pkg::OP_BACK: w_next = f_sub(i_time, w_opnd);
                tod_pkg::OP_DIFF: w_diff = w_t_ge_o ? f_sub(i_time, w_opnd)
                                                    : f_sub(w_opnd, i_time);
                default:          w_next = i_time;
            endcase
        end
    end

    assign o_rsp = '{now_hour:    w_next.hour,
                     now_minute:  w_next.minute,
                     now_second:  w_next.second,
                     diff_hour:   w_diff.hour,
                     diff_minute: w_diff.minute,
                     diff_second: w_diff.second,
                     rejected:    w_bad};

endmodule

`default_nettype wire

### hw/rtl/time_of_day_shift_and_difference.sv
// Top level: request register, stored time of day, result register.
// Depends on tod_pkg, tod_calc and time_of_day_shift_and_difference_assert.svh.
//
//   Channel  | Handshake             | Payload
//   request  | i_valid / o_stall     | i_req (tod_pkg::t_tod_req)
//   result   | o_valid / i_stall     | o_rsp (tod_pkg::t_tod_rsp)
//
// One request per clock while i_stall is low; a taken request goes to the
// request register, then through tod_calc into the result register, and the
// stored time updates at the edge that loads the result.
// Reset (synchronous, active low) empties both registers and clears the time.
// A stall on the result side holds the result register; the request register
// still fills, and o_stall rises once both registers hold a request.
`timescale 1ns / 1ps
`default_nettype none
`include "time_of_day_shift_and_difference_assert.svh"

module time_of_day_shift_and_difference (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire tod_pkg::t_tod_req i_req,
    output logic                   o_valid,
    input  wire                    i_stall,
    output tod_pkg::t_tod_rsp      o_rsp
);

    logic               r_req_valid;
    logic               n_req_valid;
    tod_pkg::t_tod_req  r_req;
    logic               r_rsp_valid;
    logic               n_rsp_valid;
    tod_pkg::t_tod_rsp  r_rsp;
    tod_pkg::t_tod_time r_time;
    tod_pkg::t_tod_time n_time;
    tod_pkg::t_tod_rsp  w_calc;
    logic               w_out_ready;
    logic               w_adv;
    logic               w_take;
    logic               w_time_ok;
    logic               w_diff_zero;

    // Flow control
    assign w_out_ready = !r_rsp_valid || !i_stall;
    assign w_adv       = r_req_valid && w_out_ready;
    assign o_stall     = r_req_valid && !w_out_ready;
    assign w_take      = i_valid && !o_stall;

    tod_calc u_calc (
        .i_req  (r_req),
        .i_time (r_time),
        .o_rsp  (w_calc)
    );

    // Next-state logic
    always_comb begin
        n_req_valid = r_req_valid;
        if (w_take) begin
            n_req_valid = 1'b1;
        end else if (w_adv) begin
            n_req_valid = 1'b0;
        end
        n_rsp_valid = r_rsp_valid;
        if (w_adv) begin
            n_rsp_valid = 1'b1;
        end else if (!i_stall) begin
            n_rsp_valid = 1'b0;
        end
        n_time = r_time;
        if (w_adv) begin
            n_time = '{hour: w_calc.now_hour, minute: w_calc.now_minute,
                       second: w_calc.now_second};
        end
    end

    // Control and stored time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_time      <= '0;
        end else begin
            r_req_valid <= n_req_valid;
            r_rsp_valid <= n_rsp_valid;
            r_time      <= n_time;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req <= i_req;
        end
        if (w_adv) begin
            r_rsp <= w_calc;
        end
    end

    assign o_valid = r_rsp_valid;
    assign o_rsp   = r_rsp;

    // Terms for the checks
    assign w_time_ok   = (r_time.hour <= tod_pkg::HOUR_MAX)
                      && (r_time.minute <= tod_pkg::MINSEC_MAX)
                      && (r_time.second <= tod_pkg::MINSEC_MAX);
    assign w_diff_zero = (o_rsp.diff_hour == 5'd0)
                      && (o_rsp.diff_minute == 6'd0)
                      && (o_rsp.diff_second == 6'd0);

    // Checks
    `TOD_ASSERT_NOW(a_time_in_range, i_clk, i_rst_n, 1'b1, w_time_ok)
    `TOD_ASSERT_NOW(a_reject_no_diff, i_clk, i_rst_n, o_valid && o_rsp.rejected, w_diff_zero)
    `TOD_ASSERT_NEXT(a_time_holds_idle, i_clk, i_rst_n, !w_adv, $stable(r_time))
    `TOD_ASSERT_NEXT(a_time_holds_reject, i_clk, i_rst_n, w_adv && w_calc.rejected, $stable(r_time))

endmodule

`default_nettype wire
